### hw/rtl/dlsq_pkg.sv
`default_nettype none
package dlsq_pkg;
    localparam int CAPACITY    = 16;
    localparam int ID_BITS     = 8;
    localparam int TIME_BITS   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_BITS    = $clog2(CAPACITY + 1);
    localparam int NRES_BITS   = $clog2(MAX_RESULTS + 1);

    typedef logic [ID_BITS-1:0]   t_id;
    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    localparam logic [2:0] KIND_DONE   = 3'd0;
    localparam logic [2:0] KIND_WOKEN  = 3'd1;
    localparam logic [2:0] KIND_POPPED = 3'd2;
    localparam logic [2:0] KIND_EMPTY  = 3'd3;
    localparam logic [2:0] KIND_FULL   = 3'd4;

    localparam logic [0:0] REG_IDLE_ID    = 1'b0;
    localparam logic [0:0] REG_GUARD_EN   = 1'b1;

    // command broadcast from the sequencer to every cell
    typedef enum logic [2:0] {
        CMD_HOLD  = 3'b001,
        CMD_SHL   = 3'b010,   // shift toward head (remove head)
        CMD_INS   = 3'b100    // insert at position / shift toward tail
    } t_cmd;

    typedef struct packed {
        t_cmd  cmd;
        t_cnt  pos;      // insert position
        t_id   thr;      // inserted id
        t_time delta;    // inserted delta
        logic  fix_next; // follower delta reduced by delta
        logic  dec_head; // head delta decrement (saturating)
    } t_ctl;
endpackage
`default_nettype wire

### hw/rtl/dlsq_if.sv
`default_nettype none
interface dlsq_in_if import dlsq_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    t_id        thread_id;
    logic [15:0] sleep_ticks;
    modport source (output valid, operation, thread_id, sleep_ticks, input ready);
    modport sink   (input valid, operation, thread_id, sleep_ticks, output ready);
endinterface

interface dlsq_out_if import dlsq_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] result_thread;
    logic [2:0] result_kind;
    logic       last_result;
    modport source (output valid, result_thread, result_kind, last_result, input ready);
    modport sink   (input valid, result_thread, result_kind, last_result, output ready);
endinterface
`default_nettype wire

### hw/rtl/dlsq_cell.sv
`default_nettype none
module dlsq_cell import dlsq_pkg::*; (
    input  wire logic  i_clk,
    input  wire t_ctl  i_ctl,
    input  wire t_cnt  i_idx,
    input  wire t_id   i_prev_thr,
    input  wire t_time i_prev_delta,
    input  wire t_id   i_next_thr,
    input  wire t_time i_next_delta,
    output t_id        o_thr,
    output t_time      o_delta
);
    t_id   r_thr, n_thr;
    t_time r_delta, n_delta;

    // per-slot update: one neighbor move per cycle
    always_comb begin
        n_thr   = r_thr;
        n_delta = r_delta;
        unique case (i_ctl.cmd)
            CMD_SHL: begin
                n_thr   = i_next_thr;
                n_delta = i_next_delta;
            end
            CMD_INS: begin
                if (i_idx > i_ctl.pos) begin
                    n_thr   = i_prev_thr;
                    n_delta = i_prev_delta;
                    if (i_ctl.fix_next && i_idx == i_ctl.pos + t_cnt'(1))
                        n_delta = i_prev_delta - i_ctl.delta;
                end else if (i_idx == i_ctl.pos) begin
                    n_thr   = i_ctl.thr;
                    n_delta = i_ctl.delta;
                end
            end
            default: begin
                if (i_ctl.dec_head && i_idx == '0 && r_delta != '0)
                    n_delta = r_delta - t_time'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_thr   <= n_thr;
        r_delta <= n_delta;
    end

    assign o_thr   = r_thr;
    assign o_delta = r_delta;
endmodule
`default_nettype wire

### hw/rtl/delta_list_sleep_queue_core.sv
// Append, pop, zero-sleep insert and full drop: the result register is loaded at the accept edge.
// Sleep insert walks past up to CAPACITY entries in ST_WALK, then inserts and gives its result.
// Tick: woken items go out one per cycle while the receiver is ready (up to MAX_RESULTS);
// a lone done when nothing wakes. One item at a time: next accepted as the last result goes.
// Reset (i_rst_n low, synchronous): queue empty, idle_id 0, guard enabled.
// Slot contents are not cleared; only occupied slots are ever read.
`default_nettype none
module delta_list_sleep_queue_core import dlsq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    dlsq_in_if.sink          s_in,
    dlsq_out_if.source       m_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:2]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_TICK = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_cnt, n_cnt;
    t_cnt   r_pos, n_pos;
    t_time  r_rem, n_rem;
    t_id    r_thr, n_thr;
    logic [NRES_BITS-1:0] r_nres, n_nres;
    t_id    r_idle;
    logic   r_guard;
    logic   r_ovalid, n_ovalid;
    t_id    r_othr, n_othr;
    logic [2:0] r_okind, n_okind;
    logic   r_olast, n_olast;
    t_ctl   ctl;

    t_id   cthr [CAPACITY];
    t_time cdel [CAPACITY];

    // chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_id   pt, nt;
        t_time pd, nd;
        if (g == 0) begin : g_h
            assign pt = '0;
            assign pd = '0;
        end else begin : g_m
            assign pt = cthr[g-1];
            assign pd = cdel[g-1];
        end
        if (g == CAPACITY - 1) begin : g_t
            assign nt = '0;
            assign nd = '0;
        end else begin : g_n
            assign nt = cthr[g+1];
            assign nd = cdel[g+1];
        end
        dlsq_cell u_cell (
            .i_clk(i_clk), .i_ctl(ctl), .i_idx(t_cnt'(g)),
            .i_prev_thr(pt), .i_prev_delta(pd),
            .i_next_thr(nt), .i_next_delta(nd),
            .o_thr(cthr[g]), .o_delta(cdel[g])
        );
    end

    // walk pointer reads one cell
    logic [$clog2(CAPACITY)-1:0] walk_idx;
    t_time walk_d;
    t_id   head_t;
    t_time head_d;
    logic  wake_more;
    assign walk_idx = r_pos[$clog2(CAPACITY)-1:0];
    assign walk_d   = cdel[walk_idx];
    assign head_t   = cthr[0];
    assign head_d   = cdel[0];

    // after the head wakes, the next cell also wakes on this tick
    assign wake_more = (r_nres != NRES_BITS'(MAX_RESULTS - 1)) && (r_cnt > t_cnt'(1))
                       && (cdel[1] == '0) && !(r_guard && cthr[1] == r_idle);

    logic out_free, in_fire;
    assign out_free = !r_ovalid || m_out.ready;
    assign s_in.ready = (r_state == ST_IDLE) && out_free;
    assign in_fire = s_in.valid && s_in.ready;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_rem    = r_rem;
        n_thr    = r_thr;
        n_nres   = r_nres;
        n_ovalid = r_ovalid && !m_out.ready;
        n_othr   = r_othr;
        n_okind  = r_okind;
        n_olast  = r_olast;
        ctl      = '{cmd: CMD_HOLD, pos: r_pos, thr: r_thr, delta: r_rem,
                     fix_next: 1'b0, dec_head: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_ovalid = 1'b1;
                    n_othr   = '0;
                    n_okind  = KIND_DONE;
                    n_olast  = 1'b1;
                    case (s_in.operation)
                        OP_INSERT: begin
                            if (s_in.sleep_ticks == '0) begin
                                n_okind = KIND_DONE;
                            end else if (r_cnt == t_cnt'(CAPACITY)) begin
                                n_okind = KIND_FULL;
                            end else begin
                                n_ovalid = 1'b0;
                                n_pos    = '0;
                                n_rem    = s_in.sleep_ticks;
                                n_thr    = s_in.thread_id;
                                n_state  = ST_WALK;
                            end
                        end
                        OP_APPEND: begin
                            if (r_cnt == t_cnt'(CAPACITY)) begin
                                n_okind = KIND_FULL;
                            end else begin
                                ctl = '{cmd: CMD_INS, pos: r_cnt, thr: s_in.thread_id,
                                        delta: '0, fix_next: 1'b0, dec_head: 1'b0};
                                n_cnt = r_cnt + t_cnt'(1);
                            end
                        end
                        OP_TICK: begin
                            if (r_cnt != '0) begin
                                n_ovalid = 1'b0;
                                ctl.dec_head = 1'b1;
                                n_nres   = '0;
                                n_state  = ST_TICK;
                            end
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                n_okind = KIND_EMPTY;
                            end else begin
                                n_okind = KIND_POPPED;
                                n_othr  = head_t;
                                ctl.cmd = CMD_SHL;
                                n_cnt   = r_cnt - t_cnt'(1);
                            end
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (r_pos < r_cnt && walk_d <= r_rem) begin
                    n_rem = r_rem - walk_d;
                    n_pos = r_pos + t_cnt'(1);
                end else if (out_free) begin
                    ctl = '{cmd: CMD_INS, pos: r_pos, thr: r_thr, delta: r_rem,
                            fix_next: (r_pos < r_cnt), dec_head: 1'b0};
                    n_cnt    = r_cnt + t_cnt'(1);
                    n_ovalid = 1'b1;
                    n_othr   = '0;
                    n_okind  = KIND_DONE;
                    n_olast  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_TICK: begin
                // one wake per cycle while the output is free; the last wake is marked as it goes out
                if (out_free) begin
                    if (r_nres != NRES_BITS'(MAX_RESULTS) && r_cnt != '0 && head_d == '0
                        && !(r_guard && head_t == r_idle)) begin
                        n_ovalid = 1'b1;
                        n_othr   = head_t;
                        n_okind  = KIND_WOKEN;
                        n_olast  = !wake_more;
                        ctl.cmd  = CMD_SHL;
                        n_cnt    = r_cnt - t_cnt'(1);
                        n_nres   = r_nres + NRES_BITS'(1);
                        if (!wake_more)
                            n_state = ST_IDLE;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            default: begin
                // nothing woke: emit a lone done
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_othr   = '0;
                    n_okind  = KIND_DONE;
                    n_olast  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_idle   <= '0;
            r_guard  <= 1'b1;
            r_nres   <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_nres   <= n_nres;
            if (psel && penable && pwrite) begin
                case (paddr[2])
                    REG_IDLE_ID:  r_idle  <= pwdata[ID_BITS-1:0];
                    default:      r_guard <= pwdata[0];
                endcase
            end
        end
        r_pos   <= n_pos;
        r_rem   <= n_rem;
        r_thr   <= n_thr;
        r_othr  <= n_othr;
        r_okind <= n_okind;
        r_olast <= n_olast;
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GUARD_EN) ? {31'd0, r_guard} : {24'd0, r_idle};

    assign m_out.valid         = r_ovalid;
    assign m_out.result_thread = r_othr;
    assign m_out.result_kind   = r_okind;
    assign m_out.last_result   = r_olast;

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_cnt'(CAPACITY)) else $error("count over capacity");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WALK |-> r_pos <= r_cnt) else $error("walk past tail");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !s_in.ready) else $error("accept while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_out.ready |=> r_ovalid) else $error("result dropped");
endmodule
`default_nettype wire

### verif/dlsq_checker.sv
`default_nettype none
module dlsq_checker import dlsq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    dlsq_in_if               in_mon,
    dlsq_out_if              out_mon,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:2]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_id        thr;
        logic [2:0] kind;
        logic       last;
    } t_wake_res;

    // shadow queue and registers
    t_id       q_thr [CAPACITY];
    t_time     q_dly [CAPACITY];
    int        q_len;
    t_id       sh_idle_id;
    logic      sh_guard;
    t_wake_res wake_results [$];
    int        errors;

    assign o_errors  = errors;
    assign o_pending = wake_results.size();

    function automatic void push_res(t_id thr, logic [2:0] kind);
        t_wake_res r;
        r.thr  = thr;
        r.kind = kind;
        r.last = 1'b0;
        wake_results.push_back(r);
    endfunction

    function automatic t_id drop_head();
        t_id thr;
        thr = q_thr[0];
        for (int i = 1; i < q_len; i++) begin
            q_thr[i-1] = q_thr[i];
            q_dly[i-1] = q_dly[i];
        end
        q_len--;
        return thr;
    endfunction

    // expected results of one accepted item
    function automatic void predict_sleep_queue(logic [1:0] op, t_id thr, t_time ticks);
        int pos;
        int nres;
        t_wake_res r;
        nres = 0;
        case (op)
            OP_INSERT: begin
                if (ticks == 0) begin
                    push_res('0, KIND_DONE);
                end else if (q_len >= CAPACITY) begin
                    push_res('0, KIND_FULL);
                end else begin
                    pos = 0;
                    while (pos < q_len && q_dly[pos] <= ticks) begin
                        ticks -= q_dly[pos];
                        pos++;
                    end
                    for (int i = q_len; i > pos; i--) begin
                        q_thr[i] = q_thr[i-1];
                        q_dly[i] = q_dly[i-1];
                    end
                    q_thr[pos] = thr;
                    q_dly[pos] = ticks;
                    q_len++;
                    if (pos + 1 < q_len)
                        q_dly[pos+1] = q_dly[pos+1] - ticks;
                    push_res('0, KIND_DONE);
                end
            end
            OP_APPEND: begin
                if (q_len >= CAPACITY) begin
                    push_res('0, KIND_FULL);
                end else begin
                    q_thr[q_len] = thr;
                    q_dly[q_len] = '0;
                    q_len++;
                    push_res('0, KIND_DONE);
                end
            end
            OP_TICK: begin
                if (q_len > 0 && q_dly[0] > 0)
                    q_dly[0]--;
                while (nres < MAX_RESULTS && q_len > 0 && q_dly[0] == 0) begin
                    if (sh_guard && q_thr[0] == sh_idle_id)
                        break;
                    push_res(drop_head(), KIND_WOKEN);
                    nres++;
                end
                if (nres == 0)
                    push_res('0, KIND_DONE);
            end
            default: begin
                if (q_len == 0)
                    push_res('0, KIND_EMPTY);
                else
                    push_res(drop_head(), KIND_POPPED);
            end
        endcase
        r = wake_results.pop_back();
        r.last = 1'b1;
        wake_results.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        t_wake_res exp_r;
        if (!i_rst_n) begin
            q_len      = 0;
            sh_idle_id = '0;
            sh_guard   = 1'b1;
            wake_results.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr == REG_IDLE_ID)
                    sh_idle_id = pwdata[ID_BITS-1:0];
                else
                    sh_guard = pwdata[0];
            end
            if (in_mon.valid && in_mon.ready)
                predict_sleep_queue(in_mon.operation, in_mon.thread_id, in_mon.sleep_ticks);
            // compare results
            if (out_mon.valid && out_mon.ready) begin
                if (wake_results.size() == 0) begin
                    $display("%0t: unexpected result thr=%0d kind=%0d last=%0b", $time,
                             out_mon.result_thread, out_mon.result_kind,
                             out_mon.last_result);
                    errors++;
                end else begin
                    exp_r = wake_results.pop_front();
                    if (out_mon.result_thread !== exp_r.thr) begin
                        $display("%0t: result_thread expected %0d actual %0d", $time,
                                 exp_r.thr, out_mon.result_thread);
                        errors++;
                    end
                    if (out_mon.result_kind !== exp_r.kind) begin
                        $display("%0t: result_kind expected %0d actual %0d", $time,
                                 exp_r.kind, out_mon.result_kind);
                        errors++;
                    end
                    if (out_mon.last_result !== exp_r.last) begin
                        $display("%0t: last_result expected %0b actual %0b", $time,
                                 exp_r.last, out_mon.last_result);
                        errors++;
                    end
                end
            end
        end
    end

    initial errors = 0;
endmodule
`default_nettype wire

### verif/tb.sv
`default_nettype none
module tb import dlsq_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:2]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          burst_left;
    int          hold_cycles;
    t_id         idle_val;

    dlsq_in_if  in_ch ();
    dlsq_out_if out_ch ();

    delta_list_sleep_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch),
        .m_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dlsq_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5ms;
        $display("delta_list_sleep_queue_core test failed");
        $finish;
    end

    // receiver: stall pattern changes every window, long hold-off on request
    initial begin
        int mode;
        out_ch.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            for (int c = 0; c < 64; c++) begin
                @(posedge i_clk);
                if (hold_cycles > 0) begin
                    out_ch.ready <= 1'b0;
                    hold_cycles--;
                end else if (mode == 0)
                    out_ch.ready <= 1'b1;
                else if (mode == 1)
                    out_ch.ready <= ($urandom_range(0, 3) != 0);
                else
                    out_ch.ready <= ($urandom_range(0, 9) < 4);
            end
        end
    end

    task automatic send_item(logic [1:0] op, t_id thr, t_time ticks);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.thread_id   <= thr;
        in_ch.sleep_ticks <= ticks;
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:2] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // random traffic, biased toward sleeps and ticks that actually wake
    task automatic random_phase(int count);
        int   sel;
        t_id  thr;
        t_time ticks;
        for (int n = 0; n < count; n++) begin
            sel   = $urandom_range(0, 99);
            thr   = ($urandom_range(0, 3) == 0) ? idle_val : t_id'($urandom);
            ticks = ($urandom_range(0, 9) == 0) ? t_time'($urandom)
                                                 : t_time'($urandom_range(0, 8));
            if (sel < 40)
                send_item(OP_INSERT, thr, ticks);
            else if (sel < 50)
                send_item(OP_APPEND, thr, t_time'($urandom));
            else if (sel < 82)
                send_item(OP_TICK, t_id'($urandom), t_time'($urandom));
            else
                send_item(OP_POP, t_id'($urandom), t_time'($urandom));
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= OP_INSERT;
        in_ch.thread_id   <= '0;
        in_ch.sleep_ticks <= '0;
        burst_left  = 0;
        hold_cycles = 0;
        idle_val    = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty queue, zero sleep, extremes, equal deltas, full queue
        send_item(OP_POP, 8'hFF, 16'hFFFF);
        send_item(OP_TICK, '0, '0);
        send_item(OP_INSERT, 8'd9, 16'd0);
        send_item(OP_INSERT, 8'hFF, 16'hFFFF);
        send_item(OP_INSERT, 8'h00, 16'd1);
        send_item(OP_INSERT, 8'hAA, 16'd3);
        send_item(OP_INSERT, 8'h55, 16'd3);
        for (int i = 0; i < 12; i++)
            send_item(OP_APPEND, t_id'(8'h10 + i), '0);
        send_item(OP_INSERT, 8'h77, 16'd2);
        send_item(OP_APPEND, 8'h78, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_POP, '0, '0);
        drain();

        // reset values: idle id 0 guarded; hold off the receiver early on
        hold_cycles = 400;
        random_phase(60);
        drain();

        idle_val = 8'd7;
        write_reg(REG_IDLE_ID, 32'd7);
        random_phase(70);
        drain();

        idle_val = 8'hFF;
        write_reg(REG_IDLE_ID, 32'hFF);
        write_reg(REG_GUARD_EN, 32'd0);
        random_phase(70);
        drain();

        // full burst of zero-delta appends, then a tick
        for (int i = 0; i < 16; i++)
            send_item(OP_APPEND, t_id'($urandom), '0);
        send_item(OP_TICK, '0, '0);
        drain();

        idle_val = 8'd7;
        write_reg(REG_IDLE_ID, 32'd7);
        random_phase(60);
        drain();

        idle_val = 8'hFF;
        write_reg(REG_IDLE_ID, 32'hFF);
        write_reg(REG_GUARD_EN, 32'd1);
        random_phase(60);
        drain();

        if (errors == 0)
            $display("delta_list_sleep_queue_core test passed");
        else
            $display("delta_list_sleep_queue_core test failed");
        $finish;
    end
endmodule
`default_nettype wire
